@@ rtl/mtse_pkg.sv @@
// Package: payload types, event codes and controller states of the slot event encoder.
package mtse_pkg;

   typedef struct packed {
      logic        operation;
      logic        first_of_request;
      logic        last_of_request;
      logic [31:0] now_seconds;
      logic [3:0]  display_id;
      logic signed [31:0] touch_id;
      logic [15:0] touch_x;
      logic [15:0] touch_y;
      logic [15:0] pressure;
      logic [15:0] axis_major;
      logic [15:0] axis_minor;
      logic        keep_alive;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_type;
      logic [5:0]  event_code;
      logic signed [31:0] event_value;
      logic [3:0]  display_out;
      logic        last_of_item;
   } rsp_type;

   localparam logic [1:0] TYPE_SYN = 2'd0;
   localparam logic [1:0] TYPE_ABS = 2'd3;
   localparam logic [5:0] CODE_SLOT   = 6'h2f;
   localparam logic [5:0] CODE_MAJOR  = 6'h30;
   localparam logic [5:0] CODE_MINOR  = 6'h31;
   localparam logic [5:0] CODE_X      = 6'h35;
   localparam logic [5:0] CODE_Y      = 6'h36;
   localparam logic [5:0] CODE_TRACK  = 6'h39;
   localparam logic [5:0] CODE_PRESS  = 6'h3a;
   localparam logic [5:0] CODE_REPORT = 6'h00;
   localparam logic [15:0] AXIS_TOP   = 16'h7FFF;
   localparam logic [31:0] AXIS_MID   = 32'd16383;
   localparam logic [31:0] VALUE_RELEASE = 32'hFFFF_FFFF;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SWEEP, ST_SWEEP_REL, ST_SEARCH, ST_DIV, ST_SLOT, ST_TRACK,
      ST_MAJOR, ST_MINOR, ST_PRESS, ST_X, ST_Y, ST_LIFT, ST_REPORT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       scan_clear;
      logic       scan_step;
      logic       scan_find;
      logic       sweep_free;
      logic       div_start;
      logic       commit;
      logic       lift_free;
      logic       emit;
      logic [5:0] code;
      logic [1:0] evtype;
      logic [3:0] vsel;
      logic       last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic expired;
      logic scan_done;
      logic found;
      logic known;
      logic sweep_final;
      logic div_done;
      logic empty;
      logic first;
      logic last;
      logic lifted;
      logic has_major;
      logic has_minor;
      logic out_busy;
   } sts_type;

   localparam logic [3:0] VSEL_SCAN    = 4'd0;
   localparam logic [3:0] VSEL_RELEASE = 4'd1;
   localparam logic [3:0] VSEL_SLOT    = 4'd2;
   localparam logic [3:0] VSEL_MAJOR   = 4'd3;
   localparam logic [3:0] VSEL_MINOR   = 4'd4;
   localparam logic [3:0] VSEL_PRESS   = 4'd5;
   localparam logic [3:0] VSEL_X       = 4'd6;
   localparam logic [3:0] VSEL_Y       = 4'd7;
   localparam logic [3:0] VSEL_ZERO    = 4'd8;

endpackage

@@ rtl/mtse_div.sv @@
// Module: restoring divider for one axis, one quotient bit per cycle.
module mtse_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   input  logic [15:0] range,
   output logic [31:0] quotient,
   output logic        done
);

   logic [31:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] den_ff, den_in;
   logic        zero_ff, zero_in;
   logic [17:0] trial;

   // Shift one numerator bit into the remainder and subtract when it fits.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      zero_in = zero_ff;
      trial   = {rem_ff, num_ff[31]} - {2'b00, den_ff};
      if (start) begin
         num_in  = 32'(value) * 32'(mtse_pkg::AXIS_TOP);
         rem_in  = '0;
         cnt_in  = 6'd32;
         den_in  = range;
         zero_in = (range == 16'd0);
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         if (!trial[17]) begin
            rem_in = trial[16:0];
            num_in = {num_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], num_ff[31]};
            num_in = {num_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   assign done     = (cnt_ff == 6'd0) && !start;
   assign quotient = zero_ff ? mtse_pkg::AXIS_MID : num_ff;

endmodule

@@ rtl/mtse_datapath.sv @@
// Module: slot table, item registers, axis dividers and output register.
module mtse_datapath #(
   parameter int SLOT_COUNT = 10,
   parameter int EXPIRE_SECONDS = 120,
   parameter int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  mtse_pkg::req_type  req_data,
   input  logic [15:0]        disp_width,
   input  logic [15:0]        disp_height,
   input  mtse_pkg::cmd_type  cmd,
   output mtse_pkg::sts_type  sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mtse_pkg::rsp_type  rsp_data
);

   mtse_pkg::req_type item_ff;
   logic [SLOT_COUNT-1:0] used_ff;
   logic [31:0] owner_ff [SLOT_COUNT];
   logic [31:0] deadline_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] forever_ff;
   logic [SW:0] scan_ff;
   logic [SW-1:0] slot_ff;
   logic [SW-1:0] exp_last_ff;
   logic found_ff, known_ff;
   logic out_valid_ff;
   mtse_pkg::rsp_type out_ff;
   logic [SW-1:0] idx;
   logic hit_known, hit_free, expired;
   logic sweep_on, gone;
   logic [32:0] dl_sum;
   logic [31:0] dl;
   logic [31:0] qx, qy, value;
   logic dx, dy;

   assign idx = scan_ff[SW-1:0];
   assign expired = used_ff[idx] && !forever_ff[idx] && (deadline_ff[idx] < item_ff.now_seconds);
   // The search already treats slots that the sweep will release as free.
   assign sweep_on  = item_ff.first_of_request || item_ff.operation;
   assign gone      = sweep_on && expired;
   assign hit_known = used_ff[idx] && !gone && (owner_ff[idx] == item_ff.touch_id);
   assign hit_free  = !used_ff[idx] || gone;
   assign dl_sum = {1'b0, item_ff.now_seconds} + 33'(EXPIRE_SECONDS);
   assign dl = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

   mtse_div u_div_x (.clock, .reset, .start(cmd.div_start), .value(item_ff.touch_x),
                     .range(disp_width), .quotient(qx), .done(dx));
   mtse_div u_div_y (.clock, .reset, .start(cmd.div_start), .value(item_ff.touch_y),
                     .range(disp_height), .quotient(qy), .done(dy));

   // Pick the event value.
   always_comb begin
      case (cmd.vsel)
         mtse_pkg::VSEL_SCAN:    value = 32'(idx);
         mtse_pkg::VSEL_RELEASE: value = mtse_pkg::VALUE_RELEASE;
         mtse_pkg::VSEL_SLOT:    value = 32'(slot_ff);
         mtse_pkg::VSEL_MAJOR:   value = 32'(item_ff.axis_major);
         mtse_pkg::VSEL_MINOR:   value = 32'(item_ff.axis_minor);
         mtse_pkg::VSEL_PRESS:   value = 32'(item_ff.pressure);
         mtse_pkg::VSEL_X:       value = qx;
         mtse_pkg::VSEL_Y:       value = qy;
         default:                value = 32'd0;
      endcase
   end

   // Slot table, scan pointer and search results.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         scan_ff  <= '0;
         found_ff <= 1'b0;
         known_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
            known_ff <= 1'b0;
         end else if (cmd.scan_clear) begin
            scan_ff  <= '0;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
            if (cmd.scan_find) begin
               if (gone) exp_last_ff <= idx;
               if (hit_known && !known_ff) begin
                  known_ff <= 1'b1;
                  found_ff <= 1'b1;
                  slot_ff  <= idx;
               end else if (hit_free && !found_ff) begin
                  found_ff <= 1'b1;
                  slot_ff  <= idx;
               end
            end
         end
         if (cmd.sweep_free) begin
            used_ff[idx] <= 1'b0;
         end
         if (cmd.commit) begin
            used_ff[slot_ff]     <= 1'b1;
            owner_ff[slot_ff]    <= item_ff.touch_id;
            deadline_ff[slot_ff] <= dl;
            forever_ff[slot_ff]  <= item_ff.keep_alive;
         end
         if (cmd.lift_free) begin
            used_ff[slot_ff] <= 1'b0;
         end
      end
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   // Output register toward the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_ff <= '{event_type: cmd.evtype, event_code: cmd.code, event_value: value,
                     display_out: item_ff.display_id, last_of_item: cmd.last};
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      sts.expired     = expired;
      sts.scan_done   = (scan_ff == (SW+1)'(SLOT_COUNT));
      sts.found       = found_ff;
      sts.known       = known_ff;
      sts.sweep_final = (idx == exp_last_ff);
      sts.div_done    = dx && dy;
      sts.empty       = item_ff.operation;
      sts.first       = sweep_on;
      sts.last        = item_ff.last_of_request || item_ff.operation;
      sts.lifted      = (item_ff.pressure == 16'd0);
      sts.has_major   = (item_ff.axis_major != 16'd0);
      sts.has_minor   = (item_ff.axis_minor != 16'd0);
      sts.out_busy    = out_valid_ff && !rsp_ready;
   end

endmodule

@@ rtl/mtse_ctrl.sv @@
// Module: controller that sequences search, sweep, division and event emission.
module mtse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mtse_pkg::sts_type  sts,
   output mtse_pkg::cmd_type  cmd
);

   mtse_pkg::state_type state_ff, state_in;
   logic act;
   logic contact_ok;
   logic last_contact;

   assign contact_ok = !sts.empty && sts.found && (sts.known || !sts.lifted);
   assign act = !sts.out_busy;
   assign last_contact = !sts.last;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mtse_pkg::ST_IDLE:
            if (req_valid) state_in = mtse_pkg::ST_SEARCH;
         mtse_pkg::ST_SEARCH:
            if (sts.scan_done) state_in = mtse_pkg::ST_SWEEP;
         mtse_pkg::ST_SWEEP:
            if (!sts.first || sts.scan_done) begin
               if (contact_ok) state_in = mtse_pkg::ST_DIV;
               else if (sts.last) state_in = mtse_pkg::ST_REPORT;
               else state_in = mtse_pkg::ST_IDLE;
            end else if (sts.expired && act) begin
               state_in = mtse_pkg::ST_SWEEP_REL;
            end
         mtse_pkg::ST_SWEEP_REL:
            if (act) state_in = mtse_pkg::ST_SWEEP;
         mtse_pkg::ST_DIV:
            state_in = mtse_pkg::ST_SLOT;
         mtse_pkg::ST_SLOT:
            if (act) state_in = sts.known ? mtse_pkg::ST_MAJOR : mtse_pkg::ST_TRACK;
         mtse_pkg::ST_TRACK:
            if (act) state_in = mtse_pkg::ST_MAJOR;
         mtse_pkg::ST_MAJOR:
            if (act || !sts.has_major) state_in = mtse_pkg::ST_MINOR;
         mtse_pkg::ST_MINOR:
            if (act || !sts.has_minor) state_in = mtse_pkg::ST_PRESS;
         mtse_pkg::ST_PRESS:
            if (act) state_in = mtse_pkg::ST_X;
         mtse_pkg::ST_X:
            if (act && sts.div_done) state_in = mtse_pkg::ST_Y;
         mtse_pkg::ST_Y:
            if (act) begin
               if (sts.lifted) state_in = mtse_pkg::ST_LIFT;
               else if (sts.last) state_in = mtse_pkg::ST_REPORT;
               else state_in = mtse_pkg::ST_IDLE;
            end
         mtse_pkg::ST_LIFT:
            if (act) state_in = sts.last ? mtse_pkg::ST_REPORT : mtse_pkg::ST_IDLE;
         mtse_pkg::ST_REPORT:
            if (act) state_in = mtse_pkg::ST_IDLE;
         default: state_in = mtse_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      cmd.evtype = mtse_pkg::TYPE_ABS;
      req_ready = 1'b0;
      unique case (state_ff)
         mtse_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
            cmd.scan_clear = 1'b1;
         end
         mtse_pkg::ST_SEARCH: begin
            cmd.scan_step = !sts.scan_done;
            cmd.scan_find = !sts.scan_done;
            cmd.scan_clear = sts.scan_done;
         end
         mtse_pkg::ST_SWEEP: begin
            if (!sts.first || sts.scan_done) begin
               cmd.scan_clear = 1'b1;
            end else if (sts.expired) begin
               cmd.emit = act;
               cmd.code = mtse_pkg::CODE_SLOT;
               cmd.vsel = mtse_pkg::VSEL_SCAN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         mtse_pkg::ST_SWEEP_REL: begin
            cmd.emit = act;
            cmd.sweep_free = act;
            cmd.scan_step = act;
            cmd.code = mtse_pkg::CODE_TRACK;
            cmd.vsel = mtse_pkg::VSEL_RELEASE;
            // The final release ends the item when no contact event or report follows.
            cmd.last = act && sts.sweep_final && !contact_ok && !sts.last;
         end
         mtse_pkg::ST_DIV: begin
            cmd.div_start = 1'b1;
            cmd.commit = 1'b1;
         end
         mtse_pkg::ST_SLOT: begin
            cmd.emit = act;
            cmd.code = mtse_pkg::CODE_SLOT;
            cmd.vsel = mtse_pkg::VSEL_SLOT;
         end
         mtse_pkg::ST_TRACK: begin
            cmd.emit = act;
            cmd.code = mtse_pkg::CODE_TRACK;
            cmd.vsel = mtse_pkg::VSEL_SLOT;
         end
         mtse_pkg::ST_MAJOR: begin
            cmd.emit = act && sts.has_major;
            cmd.code = mtse_pkg::CODE_MAJOR;
            cmd.vsel = mtse_pkg::VSEL_MAJOR;
         end
         mtse_pkg::ST_MINOR: begin
            cmd.emit = act && sts.has_minor;
            cmd.code = mtse_pkg::CODE_MINOR;
            cmd.vsel = mtse_pkg::VSEL_MINOR;
         end
         mtse_pkg::ST_PRESS: begin
            cmd.emit = act;
            cmd.code = mtse_pkg::CODE_PRESS;
            cmd.vsel = mtse_pkg::VSEL_PRESS;
         end
         mtse_pkg::ST_X: begin
            cmd.emit = act && sts.div_done;
            cmd.code = mtse_pkg::CODE_X;
            cmd.vsel = mtse_pkg::VSEL_X;
         end
         mtse_pkg::ST_Y: begin
            cmd.emit = act;
            cmd.code = mtse_pkg::CODE_Y;
            cmd.vsel = mtse_pkg::VSEL_Y;
            cmd.last = !sts.lifted && last_contact;
         end
         mtse_pkg::ST_LIFT: begin
            cmd.emit = act;
            cmd.lift_free = act;
            cmd.code = mtse_pkg::CODE_TRACK;
            cmd.vsel = mtse_pkg::VSEL_RELEASE;
            cmd.last = last_contact;
         end
         mtse_pkg::ST_REPORT: begin
            cmd.emit = act;
            cmd.evtype = mtse_pkg::TYPE_SYN;
            cmd.code = mtse_pkg::CODE_REPORT;
            cmd.vsel = mtse_pkg::VSEL_ZERO;
            cmd.last = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/multitouch_slot_event_encoder.sv @@
// Top level: multitouch protocol-B slot event encoder with configuration port.
// One item is taken at a time and turned into up to 2*SLOT_COUNT + 8 event transfers.
// After the item is taken, the slot search steps through every slot and already counts
// the slots that the expiry sweep will release as free; on the first item of a request
// the sweep then steps through every slot again and emits a slot and a release event for
// each expired slot, otherwise it passes straight on. A contact then starts the X and Y
// scaling dividers, one quotient bit a cycle, which run overlapped with the slot,
// tracking, axis and pressure events; X, once the dividers are done, Y and the release or
// report follow one a cycle while the receiver takes each result at once. The result
// register lets the last event wait while the next item is taken.
module multitouch_slot_event_encoder #(
   parameter int SLOT_COUNT = 10,
   parameter int EXPIRE_SECONDS = 120
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtse_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:2]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [15:0] width_ff, height_ff;
   mtse_pkg::cmd_type cmd;
   mtse_pkg::sts_type sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (psel && penable && pwrite) begin
         if (paddr == mtse_pkg::REG_WIDTH) width_ff <= pwdata[15:0];
         else height_ff <= pwdata[15:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == mtse_pkg::REG_WIDTH) ? 32'(width_ff) : 32'(height_ff);

   mtse_ctrl u_ctrl (.clock, .reset, .req_valid, .req_ready, .sts, .cmd);

   mtse_datapath #(.SLOT_COUNT(SLOT_COUNT), .EXPIRE_SECONDS(EXPIRE_SECONDS)) u_dp (
      .clock, .reset, .req_data, .disp_width(width_ff), .disp_height(height_ff),
      .cmd, .sts, .rsp_valid, .rsp_ready, .rsp_data);

   // A new result is only loaded when the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && !rsp_ready)) else $error("result overwritten");

   // No item is taken while a contact is being processed.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("item taken while busy");

endmodule
